[design/pol_pkg.sv]
package pol_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int POS_W        = 8;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 5;
    localparam int IDX_W        = 4;
    localparam int RESULT_LIMIT = 16;

    // Request codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Commands broadcast to every cell of the chain.
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cnt;
    } t_cell_ctl;

endpackage

[design/pol_cell.sv]
module pol_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  pol_pkg::t_cell_ctl                i_ctl,
    input  logic signed [pol_pkg::VAL_W-1:0]  i_left,
    input  logic signed [pol_pkg::VAL_W-1:0]  i_right,
    input  logic signed [pol_pkg::VAL_W-1:0]  i_head,
    input  logic signed [pol_pkg::VAL_W-1:0]  i_value,
    output logic signed [pol_pkg::VAL_W-1:0]  o_entry
);

    localparam logic [pol_pkg::POS_W-1:0] MY_IDX  = pol_pkg::POS_W'(IDX);
    localparam logic [pol_pkg::POS_W-1:0] MY_NEXT = pol_pkg::POS_W'(IDX + 1);

    logic signed [pol_pkg::VAL_W-1:0] r_entry;
    logic signed [pol_pkg::VAL_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            pol_pkg::CELL_INSERT: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_entry = i_value;
                end else if (MY_IDX > i_ctl.pos && MY_IDX <= i_ctl.cnt) begin
                    n_entry = i_left;
                end
            end
            pol_pkg::CELL_DELETE: begin
                if (MY_IDX >= i_ctl.pos && MY_NEXT < i_ctl.cnt) begin
                    n_entry = i_right;
                end
            end
            pol_pkg::CELL_ROTATE: begin
                // The occupied part of the chain turns by one toward the front.
                if (MY_NEXT < i_ctl.cnt) begin
                    n_entry = i_right;
                end else if (MY_NEXT == i_ctl.cnt) begin
                    n_entry = i_head;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[design/positional_ordered_list.sv]
// Channel   Ports                      Direction  Transaction
// request   start, busy, i_cmd         in         start high while busy is low
// result    o_strobe, o_result         out        o_strobe high for one cycle
//
// Insert, delete and unused codes give their result in the cycle after the
// request, and a new request is taken in the very next cycle.
// A dump of N entries keeps busy high while the cell chain rotates once
// around; the first min(N, 16) steps of that turn each emit one entry.
// Synchronous active-low reset empties the list; entry contents are not reset.
// The receiver cannot stall: every result is shown for exactly one cycle.
module positional_ordered_list #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pol_pkg::t_in   i_cmd,
    output logic           o_strobe,
    output pol_pkg::t_out  o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [pol_pkg::POS_W-1:0] CAP_P  = pol_pkg::POS_W'(CAPACITY);
    localparam logic [pol_pkg::POS_W-1:0] LIM_P  = pol_pkg::POS_W'(pol_pkg::RESULT_LIMIT);

    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_step, n_step;
    logic            r_busy, n_busy;
    logic            r_strobe, n_strobe;
    pol_pkg::t_out   r_res, n_res;
    pol_pkg::t_cell_ctl ctl;

    logic [pol_pkg::POS_W-1:0] cnt_p;
    logic [pol_pkg::POS_W-1:0] step_p;
    logic                      accept;

    logic signed [pol_pkg::VAL_W-1:0] entry [CAPACITY];
    logic signed [pol_pkg::VAL_W-1:0] left_in [CAPACITY];
    logic signed [pol_pkg::VAL_W-1:0] right_in [CAPACITY];

    assign cnt_p  = pol_pkg::POS_W'(r_count);
    assign step_p = pol_pkg::POS_W'(r_step);
    assign accept = start && !r_busy;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left_in[g] = i_cmd.value;
            end else begin : g_mid_l
                assign left_in[g] = entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign right_in[g] = entry[0];
            end else begin : g_mid_r
                assign right_in[g] = entry[g+1];
            end
            pol_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_left  (left_in[g]),
                .i_right (right_in[g]),
                .i_head  (entry[0]),
                .i_value (i_cmd.value),
                .o_entry (entry[g])
            );
        end
    endgenerate

    always_comb begin
        ctl.cmd  = pol_pkg::CELL_HOLD;
        ctl.pos  = i_cmd.position;
        ctl.cnt  = cnt_p;
        n_count  = r_count;
        n_step   = r_step;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        n_res    = r_res;

        if (r_busy) begin
            ctl.cmd = pol_pkg::CELL_ROTATE;
            if (step_p < LIM_P) begin
                n_strobe          = 1'b1;
                n_res.status      = pol_pkg::ST_OK;
                n_res.count       = pol_pkg::CNT_W'(r_count);
                n_res.entry_index = pol_pkg::IDX_W'(r_step);
                n_res.entry_value = entry[0];
                n_res.last        = (step_p + 8'd1 == cnt_p) || (step_p + 8'd1 == LIM_P);
            end
            n_step = r_step + 1'b1;
            if (step_p + 8'd1 == cnt_p) begin
                n_busy = 1'b0;
            end
        end else if (accept) begin
            n_res.status      = pol_pkg::ST_OK;
            n_res.entry_index = '0;
            n_res.entry_value = '0;
            n_res.last        = 1'b1;
            n_strobe          = 1'b1;
            case (i_cmd.op)
                pol_pkg::OP_INSERT: begin
                    if (cnt_p >= CAP_P) begin
                        n_res.status = pol_pkg::ST_FULL;
                    end else if (r_count == '0) begin
                        // Any position on an empty list lands at the front.
                        ctl.cmd = pol_pkg::CELL_INSERT;
                        ctl.pos = '0;
                        n_count = r_count + 1'b1;
                    end else if (i_cmd.position > cnt_p) begin
                        n_res.status = pol_pkg::ST_RANGE;
                    end else begin
                        ctl.cmd = pol_pkg::CELL_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                pol_pkg::OP_DELETE: begin
                    if (r_count == '0) begin
                        n_res.status = pol_pkg::ST_EMPTY;
                    end else if (i_cmd.position >= cnt_p) begin
                        n_res.status = pol_pkg::ST_RANGE;
                    end else begin
                        ctl.cmd = pol_pkg::CELL_DELETE;
                        n_count = r_count - 1'b1;
                    end
                end
                pol_pkg::OP_DUMP: begin
                    if (r_count != '0) begin
                        n_strobe = 1'b0;
                        n_busy   = 1'b1;
                        n_step   = '0;
                    end
                end
                default: begin
                    n_res.status = pol_pkg::ST_OK;
                end
            endcase
            n_res.count = pol_pkg::CNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_step   <= '0;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_step   <= n_step;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_p <= CAP_P)
        else $error("entry count above capacity");

    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.op == pol_pkg::OP_DUMP && r_count != '0 |=> r_busy)
        else $error("dump of a filled list did not start streaming");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.op != pol_pkg::OP_DUMP |=> r_strobe && r_res.last)
        else $error("request did not give a single final result");

    a_mid_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_res.last |-> r_busy)
        else $error("non-final result outside a dump");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> $stable(r_count))
        else $error("count changed during a dump");

endmodule

[tb/positional_ordered_list_tb.sv]
`timescale 1ns / 1ps

module positional_ordered_list_tb;

    localparam int CAP = pol_pkg::CAPACITY_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = pol_pkg::RESULT_LIMIT + 4;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 25;

    typedef struct {
        pol_pkg::t_in  cmd;
        bit            fixed;
        pol_pkg::t_out result;
    } t_step;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    pol_pkg::t_in  i_cmd;
    logic          o_strobe;
    pol_pkg::t_out o_result;

    logic signed [pol_pkg::VAL_W-1:0] list_vals [CAP];
    int   list_len;
    pol_pkg::t_out pending_results[$];
    t_step directed[$];
    int   fail_count = 0;
    int   stall_cycles = 0;
    int   sender_idle_pct = 0;

    positional_ordered_list #(.CAPACITY(CAP)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic pol_pkg::t_out pack_result(logic [1:0] status, int cnt, int idx,
                                                  logic signed [pol_pkg::VAL_W-1:0] val,
                                                  bit last_flag);
        pol_pkg::t_out r;
        r.status      = status;
        r.count       = cnt[pol_pkg::CNT_W-1:0];
        r.entry_index = idx[pol_pkg::IDX_W-1:0];
        r.entry_value = val;
        r.last        = last_flag;
        return r;
    endfunction

    // Updates the local copy of the list and queues the results it should produce.
    task automatic apply_list_op(input pol_pkg::t_in c);
        int pos;
        int n;
        logic [1:0] status;
        pos = c.position;
        status = pol_pkg::ST_OK;
        case (c.op)
            pol_pkg::OP_INSERT: begin
                if (list_len >= CAP) begin
                    status = pol_pkg::ST_FULL;
                end else begin
                    if (list_len == 0) pos = 0;
                    if (pos > list_len) begin
                        status = pol_pkg::ST_RANGE;
                    end else begin
                        for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
                        list_vals[pos] = c.value;
                        list_len++;
                    end
                end
                pending_results.push_back(pack_result(status, list_len, 0, '0, 1'b1));
            end
            pol_pkg::OP_DELETE: begin
                if (list_len == 0) begin
                    status = pol_pkg::ST_EMPTY;
                end else if (pos >= list_len) begin
                    status = pol_pkg::ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                end
                pending_results.push_back(pack_result(status, list_len, 0, '0, 1'b1));
            end
            pol_pkg::OP_DUMP: begin
                n = (list_len > pol_pkg::RESULT_LIMIT) ? pol_pkg::RESULT_LIMIT : list_len;
                if (n == 0) begin
                    pending_results.push_back(pack_result(pol_pkg::ST_OK, 0, 0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++)
                        pending_results.push_back(
                            pack_result(pol_pkg::ST_OK, list_len, i, list_vals[i], i + 1 == n));
                end
            end
            default: begin
                pending_results.push_back(pack_result(pol_pkg::ST_OK, list_len, 0, '0, 1'b1));
            end
        endcase
    endtask

    // A row with a fixed result replaces the predicted one, which is always a single result.
    task automatic send_cmd(input pol_pkg::t_in c, input bit fixed,
                            input pol_pkg::t_out fixed_result);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        apply_list_op(c);
        if (fixed) pending_results[pending_results.size()-1] = fixed_result;
    endtask

    task automatic add_step(input logic [1:0] op, input int pos,
                            input logic signed [pol_pkg::VAL_W-1:0] val, input bit fixed,
                            input logic [1:0] status, input int cnt);
        t_step s;
        s.cmd.op       = op;
        s.cmd.position = pos[pol_pkg::POS_W-1:0];
        s.cmd.value    = val;
        s.fixed        = fixed;
        s.result       = pack_result(status, cnt, 0, '0, 1'b1);
        directed.push_back(s);
    endtask

    function automatic pol_pkg::t_in random_cmd(int ins_pct, int del_pct);
        pol_pkg::t_in c;
        int pick;
        pick = $urandom_range(99);
        if (pick < ins_pct)
            c.op = pol_pkg::OP_INSERT;
        else if (pick < ins_pct + del_pct)
            c.op = pol_pkg::OP_DELETE;
        else if (pick < 94)
            c.op = pol_pkg::OP_DUMP;
        else
            c.op = OP_UNUSED;
        // Mostly positions near the valid range, sometimes anywhere in the field.
        if ($urandom_range(9) < 8)
            c.position = pol_pkg::POS_W'($urandom_range(list_len));
        else
            c.position = pol_pkg::POS_W'($urandom_range(255));
        c.value = $urandom();
        return c;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin
        pol_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf(
                    "unexpected transaction: status %0d count %0d index %0d value %0d last %0b",
                    o_result.status, o_result.count, o_result.entry_index,
                    o_result.entry_value, o_result.last));
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status || o_result.count !== want.count ||
                    o_result.entry_index !== want.entry_index ||
                    o_result.entry_value !== want.entry_value ||
                    o_result.last !== want.last) begin
                    note_failure($sformatf({
                        "mismatch: expected status %0d count %0d index %0d value %0d last %0b,",
                        " got status %0d count %0d index %0d value %0d last %0b"},
                        want.status, want.count, want.entry_index, want.entry_value,
                        want.last, o_result.status, o_result.count, o_result.entry_index,
                        o_result.entry_value, o_result.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int ins_pct;
        int del_pct;
        pol_pkg::t_out unused_result;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        unused_result = '0;
        list_len = 0;
        for (int i = 0; i < CAP; i++) list_vals[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list, single entry, front insert, append, dump, unused-code and out-of-range requests.
        add_step(pol_pkg::OP_DUMP,   0,   '0,            1'b1, pol_pkg::ST_OK,    0);
        add_step(pol_pkg::OP_DELETE, 255, '0,            1'b1, pol_pkg::ST_EMPTY, 0);
        add_step(pol_pkg::OP_INSERT, 255, 32'sh7FFFFFFF, 1'b1, pol_pkg::ST_OK,    1);
        add_step(pol_pkg::OP_DELETE, 1,   '0,            1'b1, pol_pkg::ST_RANGE, 1);
        add_step(pol_pkg::OP_INSERT, 0,   32'sh80000000, 1'b1, pol_pkg::ST_OK,    2);
        add_step(pol_pkg::OP_INSERT, 3,   32'sh12345678, 1'b1, pol_pkg::ST_RANGE, 2);
        add_step(pol_pkg::OP_INSERT, 2,   -32'sd1,       1'b1, pol_pkg::ST_OK,    3);
        add_step(pol_pkg::OP_DUMP,   0,   '0,            1'b0, pol_pkg::ST_OK,    0);
        add_step(OP_UNUSED,          255, 32'shAAAAAAAA, 1'b1, pol_pkg::ST_OK,    3);
        add_step(pol_pkg::OP_DELETE, 255, '0,            1'b1, pol_pkg::ST_RANGE, 3);
        // Fill the list at scattered positions, then hit the full and boundary cases.
        for (int i = 0; i < CAP - 3; i++)
            add_step(pol_pkg::OP_INSERT, (i * 7) % (4 + i),
                     32'sh11111111 * (i + 1) ^ 32'sh5A5A0000, 1'b0, pol_pkg::ST_OK, 0);
        add_step(pol_pkg::OP_INSERT, 0,   32'sh0F0F0F0F, 1'b1, pol_pkg::ST_FULL,  CAP);
        add_step(pol_pkg::OP_DUMP,   0,   '0,            1'b0, pol_pkg::ST_OK,    0);
        add_step(pol_pkg::OP_DELETE, 0,   '0,            1'b0, pol_pkg::ST_OK,    0);
        add_step(pol_pkg::OP_DELETE, CAP - 1, '0,        1'b1, pol_pkg::ST_RANGE, CAP - 1);

        sender_idle_pct = 10;
        foreach (directed[k]) send_cmd(directed[k].cmd, directed[k].fixed, directed[k].result);

        // Each phase leans toward a different fill level of the list.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 10; ins_pct = 60; del_pct = 20; end
                1: begin sender_idle_pct = 46; ins_pct = 25; del_pct = 55; end
                default: begin sender_idle_pct = 0; ins_pct = 45; del_pct = 35; end
            endcase
            repeat (PHASE_ITEMS) send_cmd(random_cmd(ins_pct, del_pct), 1'b0, unused_result);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d expected transactions never arrived",
                                   pending_results.size()));

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[positional_ordered_list.f]
design/pol_pkg.sv
design/pol_cell.sv
design/positional_ordered_list.sv
tb/positional_ordered_list_tb.sv
